[src/bounded_shift_stack_macros.svh]
// assertion macros for the bounded shift stack
`ifndef BOUNDED_SHIFT_STACK_MACROS_SVH
`define BOUNDED_SHIFT_STACK_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bounded_shift_stack assertion failed");
// next-cycle implication
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bounded_shift_stack assertion failed");
`else
`define BSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/bss_pkg.sv]
// shared types and constants of the bounded shift stack
package bss_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [CAP_W-1:0] DEFAULT_CAP = CAP_W'(10);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ENTRY      = 2'd0,
    KIND_EMPTY_LIST = 2'd1,
    KIND_FULL       = 2'd2,
    KIND_EMPTY_ERR  = 2'd3
  } kind_e;

  // per-cycle controls broadcast to every cell of the row
  typedef struct packed {
    logic push;   // entries move one place down, value enters on top
    logic pop;    // entries move one place up, zero enters at the bottom
    logic load;   // copy the new entries into the listing row
    logic shift;  // listing row moves one place toward the top
  } cell_ctrl_t;

endpackage

[src/bounded_shift_stack.sv]
// top level of the bounded shift stack: cell row, sequencer and output register
//
//  channel  | dir | handshake                    | contents
//  ---------+-----+------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: value, tuser: operation
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: entry_value, tuser: kind, tlast
//  cfg      | in  | cfg_we_i                     | cfg_wdata_i: capacity_limit
//
// a push or pop that leaves n entries is accepted, then yields n listing words, one per cycle
// while the output register is not stalled, shifted out of the top of the listing row
// a full error, empty error or empty listing yields one word; clear yields none
// reset clears the count, the sequencer and the output register; the limit returns to ten
// a stalled output register holds the row; no input word is taken while a listing runs
`include "bounded_shift_stack_macros.svh"

module bounded_shift_stack #(
  parameter int unsigned DEPTH = bss_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [bss_pkg::CAP_W-1:0]  cfg_wdata_i,    // [4:0] capacity_limit
  // input words
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bss_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]                 s_axis_tuser,   // [1:0] operation
  // result words
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bss_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] entry_value
  output logic [1:0]                 m_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tlast    // last
);
  import bss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // configuration register
  logic [CAP_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= DEFAULT_CAP;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // effective capacity: zero means default, never above the row depth
  logic [CAP_W-1:0] cap_raw;
  logic [CMP_W-1:0] cap_eff;
  always_comb begin
    cap_raw = (cap_q == '0) ? DEFAULT_CAP : cap_q;
    if (CMP_W'(cap_raw) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(cap_raw);
    end
  end

  // sequencer state
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] rem_q, rem_d;     // listing words still to emit
  kind_e            kind_q, kind_d;   // kind of the words being emitted
  logic [CNT_W-1:0] count_q, count_d;

  // output register
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              advance;
  logic              full;
  op_e               op;

  logic [DATA_W-1:0] entry_w [DEPTH];
  logic [DATA_W-1:0] list_w  [DEPTH];

  assign s_axis_tready = !busy_q;
  assign accept  = s_axis_tvalid && !busy_q;
  assign advance = busy_q && (!out_valid_q || m_axis_tready);
  assign op      = op_e'(s_axis_tuser);
  assign full    = CMP_W'(count_q) >= cap_eff;

  // decode of an accepted word and listing progress
  always_comb begin
    busy_d     = busy_q;
    rem_d      = rem_q;
    kind_d     = kind_q;
    count_d    = count_q;
    ctrl       = '0;
    ctrl.shift = advance;
    if (advance) begin
      rem_d = rem_q - CNT_W'(1);
      if (rem_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      case (op)
        OP_PUSH: begin
          busy_d = 1'b1;
          if (full) begin
            kind_d = KIND_FULL;
            rem_d  = CNT_W'(1);
          end else begin
            ctrl.push = 1'b1;
            ctrl.load = 1'b1;
            count_d   = count_q + CNT_W'(1);
            kind_d    = KIND_ENTRY;
            rem_d     = count_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          busy_d = 1'b1;
          rem_d  = CNT_W'(1);
          if (count_q == '0) begin
            kind_d = KIND_EMPTY_ERR;
          end else begin
            ctrl.pop  = 1'b1;
            ctrl.load = 1'b1;
            count_d   = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              kind_d = KIND_EMPTY_LIST;
            end else begin
              kind_d = KIND_ENTRY;
              rem_d  = count_q - CNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          // unused code: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rem_q   <= '0;
      kind_q  <= KIND_ENTRY;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      rem_q   <= rem_d;
      kind_q  <= kind_d;
      count_q <= count_d;
    end
  end

  // row of cells, slot 0 on top
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    logic [DATA_W-1:0] list_below;
    if (i == 0) begin : g_top
      assign above = s_axis_tdata;
    end else begin : g_mid
      assign above = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_bottom
      assign below      = '0;
      assign list_below = '0;
    end else begin : g_upper
      assign below      = entry_w[i+1];
      assign list_below = list_w[i+1];
    end
    bss_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .above_i      (above),
      .below_i      (below),
      .list_below_i (list_below),
      .entry_o      (entry_w[i]),
      .list_o       (list_w[i])
    );
  end

  // output register: refilled from the top of the listing row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ENTRY;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      out_kind_q  <= kind_q;
      out_data_q  <= (kind_q == KIND_ENTRY) ? list_w[0] : '0;
      out_last_q  <= (rem_q == CNT_W'(1));
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  `BSS_ASSERT_SAME(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `BSS_ASSERT_SAME(a_busy_has_words, clk_i, rst_ni, busy_q, rem_q != '0)
  `BSS_ASSERT_NEXT(a_push_pop_starts, clk_i, rst_ni,
    accept && (op == OP_PUSH || op == OP_POP), busy_q)
  `BSS_ASSERT_SAME(a_single_word_last, clk_i, rst_ni,
    out_valid_q && out_kind_q != KIND_ENTRY, out_last_q)
  `BSS_ASSERT_SAME(a_listing_fits, clk_i, rst_ni,
    busy_q && kind_q == KIND_ENTRY, rem_q <= count_q)

endmodule

[src/bss_cell.sv]
// one stack slot: stored entry plus its place in the listing row
module bss_cell (
  input  logic                       clk_i,
  input  bss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [bss_pkg::DATA_W-1:0] above_i,       // entry of the slot above
  input  logic [bss_pkg::DATA_W-1:0] below_i,       // entry of the slot below
  input  logic [bss_pkg::DATA_W-1:0] list_below_i,  // listing word of the slot below
  output logic [bss_pkg::DATA_W-1:0] entry_o,
  output logic [bss_pkg::DATA_W-1:0] list_o
);
  import bss_pkg::*;

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [DATA_W-1:0] list_q, list_d;

  always_comb begin
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_comb begin
    if (ctrl_i.load) begin
      list_d = entry_d;
    end else if (ctrl_i.shift) begin
      list_d = list_below_i;
    end else begin
      list_d = list_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    list_q  <= list_d;
  end

  assign entry_o = entry_q;
  assign list_o  = list_q;

endmodule

[bench/bss_checker.sv]
// watcher for the bounded shift stack: predicts every result word and compares it
module bss_checker #(
  parameter int unsigned DEPTH = bss_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bss_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       s_valid_i,
  input  logic                       s_ready_i,
  input  logic [bss_pkg::DATA_W-1:0] s_data_i,
  input  logic [1:0]                 s_user_i,
  input  logic                       m_valid_i,
  input  logic                       m_ready_i,
  input  logic [bss_pkg::DATA_W-1:0] m_data_i,
  input  logic [1:0]                 m_user_i,
  input  logic                       m_last_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import bss_pkg::*;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } stack_word_t;

  logic [DATA_W-1:0] entry_q [DEPTH];
  int unsigned       fill_q;
  logic [CAP_W-1:0]  limit_q;
  stack_word_t       due_words [$];
  int                mism;

  // zero picks the default, anything above the depth saturates
  function automatic int unsigned room_now();
    int unsigned c;
    c = limit_q;
    if (c == 0) c = DEFAULT_CAP;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic stack_word_t word_of(kind_e k, logic [DATA_W-1:0] v, logic l);
    stack_word_t w;
    w.kind  = k;
    w.value = v;
    w.last  = l;
    return w;
  endfunction

  task automatic list_entries();
    if (fill_q == 0) begin
      due_words.push_back(word_of(KIND_EMPTY_LIST, '0, 1'b1));
    end else begin
      for (int unsigned i = 0; i < fill_q; i++)
        due_words.push_back(word_of(KIND_ENTRY, entry_q[i], i + 1 == fill_q));
    end
  endtask

  task automatic apply_op(logic [1:0] op, logic [DATA_W-1:0] val);
    case (op)
      OP_PUSH: begin
        if (fill_q >= room_now()) begin
          due_words.push_back(word_of(KIND_FULL, '0, 1'b1));
        end else begin
          for (int unsigned i = fill_q; i > 0; i--) entry_q[i] = entry_q[i-1];
          entry_q[0] = val;
          fill_q++;
          list_entries();
        end
      end
      OP_POP: begin
        if (fill_q == 0) begin
          due_words.push_back(word_of(KIND_EMPTY_ERR, '0, 1'b1));
        end else begin
          for (int unsigned i = 0; i + 1 < fill_q; i++) entry_q[i] = entry_q[i+1];
          entry_q[fill_q-1] = '0;
          fill_q--;
          list_entries();
        end
      end
      OP_CLEAR: fill_q = 0;
      default: ;
    endcase
  endtask

  task automatic check_word();
    stack_word_t want;
    if (due_words.size() == 0) begin
      mism++;
      if (mism <= 10)
        $display("unexpected word: kind %0d value %h last %0b", m_user_i, m_data_i, m_last_i);
    end else begin
      want = due_words.pop_front();
      if (m_user_i !== want.kind || m_data_i !== want.value || m_last_i !== want.last) begin
        mism++;
        if (mism <= 10)
          $display("word mismatch: expected kind %0d value %h last %0b, got kind %0d value %h last %0b",
                   want.kind, want.value, want.last, m_user_i, m_data_i, m_last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) entry_q[i] = '0;
      fill_q  = 0;
      limit_q = DEFAULT_CAP;
      due_words.delete();
      mism = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_valid_i && m_ready_i) check_word();
      if (s_valid_i && s_ready_i) apply_op(s_user_i, s_data_i);
      if (cfg_we_i) limit_q = cfg_wdata_i;
      pending_o    <= due_words.size();
      fail_count_o <= mism;
    end
  end

endmodule

[bench/tb.sv]
// top of the bounded shift stack bench: clock, reset, stimulus and verdict
module tb;
  import bss_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEFAULT;
  // longest listing is one word per entry; the drain wait adds a margin beyond it
  localparam int unsigned DRAIN_CYCLES = STACK_DEPTH + 8;
  // the fourth operation code, which the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_value  = '0;
  logic [1:0]        in_op     = OP_PUSH;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_value;
  logic [1:0]        out_kind;
  logic              out_last;
  int                fails;
  int                pending;

  // both sides run without gaps while this is set
  bit quiet = 1'b0;
  // asks the receiver for one long hold-off
  bit long_hold = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_shift_stack #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),   // [4:0] capacity_limit
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_value),    // [31:0] value
    .s_axis_tuser  (in_op),       // [1:0] operation
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_value),   // [31:0] entry_value
    .m_axis_tuser  (out_kind),    // [1:0] kind
    .m_axis_tlast  (out_last)
  );

  bss_checker #(
    .DEPTH(STACK_DEPTH)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_valid_i    (in_valid),
    .s_ready_i    (in_ready),
    .s_data_i     (in_value),
    .s_user_i     (in_op),
    .m_valid_i    (out_valid),
    .m_ready_i    (out_ready),
    .m_data_i     (out_value),
    .m_user_i     (out_kind),
    .m_last_i     (out_last),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // extremes show up often enough to hit the sign bit and all-ones patterns
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // a few ignored codes and clears, the rest split between push and pop
  function automatic logic [1:0] pick_op(int unsigned push_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    if (r < 8) return OP_CLEAR;
    if (r < 8 + push_w) return OP_PUSH;
    return OP_POP;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(logic [1:0] op, logic [DATA_W-1:0] v);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // random idle gap on the input side, with junk on the data lines
  task automatic pause_tx();
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      in_op    <= 2'($urandom_range(0, 3));
      repeat (g) @(posedge clk);
    end
  endtask

  // stop offering, wait for every predicted word, then let a clear finish too
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // the limit is only changed while the block sits idle
  task automatic write_limit(logic [CAP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned rx_gap;
    rx_gap = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        rx_gap = gap_len();
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      sent;
    int unsigned      n_items;
    int unsigned      push_w;
    logic [1:0]       op;
    logic [CAP_W-1:0] cap;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: pop on an empty stack, the ignored code, clear on empty
    send_word(OP_POP, $urandom);     pause_tx();
    send_word(OP_UNUSED, $urandom);  pause_tx();
    send_word(OP_CLEAR, $urandom);   pause_tx();
    // value extremes, listed back after each push
    send_word(OP_PUSH, 32'h8000_0000); pause_tx();
    send_word(OP_PUSH, 32'h7fff_ffff); pause_tx();
    send_word(OP_PUSH, 32'hffff_ffff); pause_tx();
    send_word(OP_PUSH, 32'h0000_0000); pause_tx();
    // pops down to nothing, the last one gives the empty listing
    repeat (4) begin
      send_word(OP_POP, $urandom); pause_tx();
    end
    // clear hides what was stored, so the next pop is an empty error
    send_word(OP_PUSH, 32'h5a5a_5a5a); pause_tx();
    send_word(OP_CLEAR, $urandom);     pause_tx();
    send_word(OP_POP, $urandom);       pause_tx();

    // small limit: fill it, then one push too many
    write_limit(5'd2);
    send_word(OP_PUSH, 32'h0000_0001); pause_tx();
    send_word(OP_PUSH, 32'h0000_0002); pause_tx();
    send_word(OP_PUSH, 32'h0000_0003); pause_tx();
    // limit lowered below the fill level: push is refused, entries stay
    write_limit(5'd1);
    send_word(OP_PUSH, 32'h0000_0004); pause_tx();
    send_word(OP_POP, $urandom);       pause_tx();

    // random phases, each with its own limit and push bias
    for (int ph = 0; ph < 7; ph++) begin
      n_items = 18;
      push_w  = (ph % 2 == 0) ? 50 : 65;
      case (ph)
        0: cap = 5'd0;                          // default of ten
        1: begin
          cap = 5'd31;                          // saturates to the depth
          n_items = 30;
          push_w  = 80;
        end
        2: cap = 5'd16;
        3: cap = 5'd1;
        4: cap = 5'd17;
        5: cap = 5'd3;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      write_limit(cap);
      quiet = (ph == 2);
      sent = 0;
      while (sent < n_items) begin
        // long hold-off while pushes keep coming, so the block backs up
        if (ph == 1 && sent == 4) long_hold = 1'b1;
        op = pick_op(push_w);
        send_word(op, pick_value());
        pause_tx();
        if (op != OP_UNUSED) sent++;
      end
      quiet = 1'b0;
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bss_pkg.sv
src/bss_cell.sv
src/bounded_shift_stack.sv
bench/bss_checker.sv
bench/tb.sv
